// File: rtl/core/jdcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_pkg
// shared types and constants of the joystick drive command mapper
// ----------------------------------------------------------------------------
package jdcm_pkg;

    localparam int GEAR_COUNT_DEF   = 5;
    localparam int RECORD_DEPTH_DEF = 256;
    localparam int GEAR_W           = 3;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int VEL_W       = 16;
    localparam int STEP_W      = 5;

    localparam logic [CFG_DATA_W-1:0] LIN_FS_RST   = 15'd3604;
    localparam logic [CFG_DATA_W-1:0] ANG_FS_RST   = 15'd14746;
    localparam logic [CFG_DATA_W-1:0] REC_LIN_RST  = 15'd328;
    localparam logic [CFG_DATA_W-1:0] REC_ANG_RST  = 15'd3277;
    localparam logic [CFG_DATA_W-1:0] SLOW_LIM_RST = 15'd1638;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_FS   = 3'd0,
        CFG_ANG_FS   = 3'd1,
        CFG_REC_LIN  = 3'd2,
        CFG_REC_ANG  = 3'd3,
        CFG_SLOW_LIM = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] ZONE_BLOCKED = 2'd0;
    localparam logic [1:0] ZONE_FREE    = 2'd1;
    localparam logic [1:0] ZONE_SLOW    = 2'd2;

    localparam logic [2:0] ZONE_TOP          = 3'd0;
    localparam logic [2:0] ZONE_TOP_RIGHT    = 3'd1;
    localparam logic [2:0] ZONE_TOP_LEFT     = 3'd2;
    localparam logic [2:0] ZONE_BOTTOM       = 3'd3;
    localparam logic [2:0] ZONE_BOTTOM_RIGHT = 3'd4;
    localparam logic [2:0] ZONE_BOTTOM_LEFT  = 3'd5;
    localparam int         ZONE_COUNT        = 6;

    localparam logic signed [STEP_W-1:0] STEP_H = 5'sd10;
    localparam logic signed [STEP_W-1:0] STEP_V = 5'sd1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_MUL2 = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic div;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic zone_item;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/joystick_drive_command_mapper.sv
`timescale 1ns / 1ps
// a joystick sample is registered on transfer and passes two multiply steps,
//   the reciprocal divide and the finish step of the shared scaling datapath
//   into the output register; finish waits on a stalled output, and no new
//   sample is taken until it is done; a zone update gives no output
// reset (synchronous, active low) restores register defaults, gear 0, empty
//   stack, all zones free; stack contents are not cleared
// ----------------------------------------------------------------------------
// joystick_drive_command_mapper
// gamepad samples to linear and angular velocity with record and replay
// ----------------------------------------------------------------------------
module joystick_drive_command_mapper #(
    parameter int GEAR_COUNT   = jdcm_pkg::GEAR_COUNT_DEF,
    parameter int RECORD_DEPTH = jdcm_pkg::RECORD_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // turn_stick, throttle_forward, throttle_reverse, shift_down, shift_up,
    // clear_button, replay_button, hat_horizontal, hat_vertical, zone_slot,
    // zone_level, zero fill
    input  logic [jdcm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // mode
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // linear_velocity, angular_velocity, window_step, zero fill
    output logic [jdcm_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // window_valid, replaying
    output logic [jdcm_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jdcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jdcm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    jdcm_pkg::t_cmd  cmd;
    jdcm_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    jdcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    jdcm_dp #(
        .GEAR_COUNT   (GEAR_COUNT),
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

// File: rtl/core/jdcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_ctrl
// sequencer: accept, two multiply steps, reciprocal divide, finish
// ----------------------------------------------------------------------------
module jdcm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  jdcm_pkg::t_stat  i_stat,
    output jdcm_pkg::t_cmd   o_cmd
);

    jdcm_pkg::t_state r_state;
    jdcm_pkg::t_state n_state;
    logic             accept;

    assign o_s_tready = (r_state == jdcm_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        o_cmd.mul1 = (r_state == jdcm_pkg::ST_MUL1);
        o_cmd.mul2 = (r_state == jdcm_pkg::ST_MUL2);
        o_cmd.div  = (r_state == jdcm_pkg::ST_DIV);
        o_cmd.fin  = (r_state == jdcm_pkg::ST_FIN) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jdcm_pkg::ST_IDLE: begin
                if (accept && !i_stat.zone_item) n_state = jdcm_pkg::ST_MUL1;
            end
            jdcm_pkg::ST_MUL1: n_state = jdcm_pkg::ST_MUL2;
            jdcm_pkg::ST_MUL2: n_state = jdcm_pkg::ST_DIV;
            jdcm_pkg::ST_DIV:  n_state = jdcm_pkg::ST_FIN;
            jdcm_pkg::ST_FIN: begin
                if (i_stat.out_free) n_state = jdcm_pkg::ST_IDLE;
            end
            default: n_state = jdcm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jdcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/jdcm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_dp
// datapath: gear and edge state, velocity scaling, record stack, zone gating
// ----------------------------------------------------------------------------
module jdcm_dp #(
    parameter int GEAR_COUNT   = jdcm_pkg::GEAR_COUNT_DEF,
    parameter int RECORD_DEPTH = jdcm_pkg::RECORD_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jdcm_pkg::t_cmd                      i_cmd,
    output jdcm_pkg::t_stat                     o_stat,
    input  logic [jdcm_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_cfg_valid,
    input  logic [jdcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jdcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [jdcm_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [jdcm_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);

    localparam int CW      = $clog2(RECORD_DEPTH + 1);
    localparam int AW      = $clog2(RECORD_DEPTH);
    localparam int P1_W    = 31;
    localparam int P2_W    = 34;
    localparam int T_W     = 19;
    localparam int SH      = T_W + 3;
    localparam int R_W     = SH + 1;
    localparam logic [P2_W-1:0] HALF  = P2_W'(GEAR_COUNT * 16384);
    localparam logic [R_W-1:0]  RECIP =
        R_W'(((64'd1 << SH) + 64'(GEAR_COUNT) - 64'd1) / 64'(GEAR_COUNT));
    localparam logic [jdcm_pkg::GEAR_W-1:0] GEAR_MAX =
        jdcm_pkg::GEAR_W'(GEAR_COUNT - 1);

    // configuration
    logic [jdcm_pkg::CFG_DATA_W-1:0] r_lin_fs, r_ang_fs, r_rec_lin, r_rec_ang, r_slow;

    // control state
    logic [jdcm_pkg::GEAR_W-1:0] r_gear, n_gear;
    logic                        r_armed, n_armed;
    logic                        r_clr_prev, r_rpl_prev, r_replay_active;
    logic [1:0]                  r_hat_h_prev, r_hat_v_prev;
    logic [CW-1:0]               r_count;
    logic [1:0]                  r_zone [jdcm_pkg::ZONE_COUNT];

    // stack memory
    logic [31:0]                 r_stack [RECORD_DEPTH];
    logic [31:0]                 r_rd;

    // pipeline payload
    logic [15:0]                 r_lmag, r_amag;
    logic                        r_lneg, r_aneg;
    logic [P1_W-1:0]             r_pl, r_pa;
    logic [P2_W-1:0]             r_ml, r_ma;
    logic [T_W-1:0]              r_ql, r_qa;
    logic signed [jdcm_pkg::STEP_W-1:0] r_step, n_step;

    // output register
    logic                        r_ov;
    logic signed [jdcm_pkg::VEL_W-1:0]  r_olin, r_oang;
    logic signed [jdcm_pkg::STEP_W-1:0] r_ostep;
    logic                        r_owv, r_orp;

    // input fields
    logic signed [15:0] f_turn;
    logic [15:0]        f_fwd, f_rev, fwd_c, rev_c;
    logic               f_sd, f_su, f_clr, f_rpl;
    logic [1:0]         f_hh, f_hv;
    logic [2:0]         f_slot;
    logic [1:0]         f_level;
    logic               clr_edge, rpl_edge;

    assign f_turn  = i_s_tdata[15:0];
    assign f_fwd   = i_s_tdata[31:16];
    assign f_rev   = i_s_tdata[47:32];
    assign f_sd    = i_s_tdata[48];
    assign f_su    = i_s_tdata[49];
    assign f_clr   = i_s_tdata[50];
    assign f_rpl   = i_s_tdata[51];
    assign f_hh    = i_s_tdata[53:52];
    assign f_hv    = i_s_tdata[55:54];
    assign f_slot  = i_s_tdata[58:56];
    assign f_level = i_s_tdata[60:59];

    assign fwd_c    = (f_fwd > 16'd32768) ? 16'd32768 : f_fwd;
    assign rev_c    = (f_rev > 16'd32768) ? 16'd32768 : f_rev;
    assign clr_edge = r_clr_prev && !f_clr;
    assign rpl_edge = r_rpl_prev && !f_rpl;

    assign o_stat.zone_item = i_s_tuser;
    assign o_stat.out_free  = !r_ov || i_m_tready;

    // gear shift
    always_comb begin
        n_gear  = r_gear;
        n_armed = r_armed | (~f_sd & ~f_su);
        if (n_armed && (f_sd ^ f_su)) begin
            if (f_sd) begin
                if (r_gear != '0) n_gear = r_gear - 1'b1;
            end else if (r_gear < GEAR_MAX) begin
                n_gear = r_gear + 1'b1;
            end
            n_armed = 1'b0;
        end
    end

    // window step from hat releases
    always_comb begin
        n_step = '0;
        if (f_hh == 2'b00 && r_hat_h_prev[1]) begin
            n_step = jdcm_pkg::STEP_H;
        end else if (f_hh == 2'b00 && r_hat_h_prev != 2'b00) begin
            n_step = -jdcm_pkg::STEP_H;
        end
        if (f_hv == 2'b00 && r_hat_v_prev[1]) begin
            n_step = n_step - jdcm_pkg::STEP_V;
        end else if (f_hv == 2'b00 && r_hat_v_prev != 2'b00) begin
            n_step = n_step + jdcm_pkg::STEP_V;
        end
    end

    // scaling: magnitude times full scale, times gear plus one, then reciprocal divide
    logic [3:0]        gear_p1;
    logic [P2_W-1:0]   sum_l, sum_a;
    logic [T_W+R_W-1:0] prod_l, prod_a;

    assign gear_p1 = {1'b0, r_gear} + 4'd1;
    assign sum_l   = r_ml + HALF;
    assign sum_a   = r_ma + HALF;
    assign prod_l  = sum_l[P2_W-1:15] * RECIP;
    assign prod_a  = sum_a[P2_W-1:15] * RECIP;

    function automatic logic signed [15:0] sat_mag(input logic [T_W-1:0] q, input logic neg);
        logic signed [15:0] r;
        if (neg) begin
            if (q > T_W'(32768)) r = 16'sh8000;
            else r = -$signed(q[15:0]);
        end else begin
            if (q > T_W'(32767)) r = 16'sh7fff;
            else r = $signed(q[15:0]);
        end
        return r;
    endfunction

    // finish: replay or record, then zone gating
    logic signed [15:0] lin_s, ang_s, lin_v, ang_v, lin_g, ang_g, nl, na;
    logic [16:0]        abs_l, abs_a;
    logic               pop, rec, push;
    logic signed [16:0] slow_p, slow_n;
    logic [CW-1:0]      cnt_dec;
    logic [AW-1:0]      rd_addr;

    assign cnt_dec = r_count - 1'b1;
    assign rd_addr = cnt_dec[AW-1:0];
    assign slow_p  = {2'b00, r_slow};
    assign slow_n  = -slow_p;

    always_comb begin
        lin_s = sat_mag(r_ql, r_lneg);
        ang_s = sat_mag(r_qa, r_aneg);
        pop   = r_replay_active && (r_count != '0);
        lin_v = pop ? $signed(r_rd[15:0])  : lin_s;
        ang_v = pop ? $signed(r_rd[31:16]) : ang_s;
        abs_l = lin_v[15] ? 17'(-{lin_v[15], lin_v}) : {1'b0, lin_v};
        abs_a = ang_v[15] ? 17'(-{ang_v[15], ang_v}) : {1'b0, ang_v};
        rec   = !r_replay_active &&
                ((abs_l > {2'b00, r_rec_lin}) || (abs_a > {2'b00, r_rec_ang}));
        push  = rec && (r_count < CW'(RECORD_DEPTH));
        nl    = (lin_v == 16'sh8000) ? 16'sh7fff : -lin_v;
        na    = (ang_v == 16'sh8000) ? 16'sh7fff : -ang_v;

        lin_g = lin_v;
        if (lin_v > 16'sd0) begin
            if (r_zone[jdcm_pkg::ZONE_TOP] == jdcm_pkg::ZONE_BLOCKED) begin
                lin_g = '0;
            end else if (r_zone[jdcm_pkg::ZONE_TOP] == jdcm_pkg::ZONE_SLOW &&
                         17'(lin_v) > slow_p) begin
                lin_g = 16'(slow_p);
            end
        end else begin
            if (r_zone[jdcm_pkg::ZONE_BOTTOM] == jdcm_pkg::ZONE_BLOCKED) begin
                lin_g = '0;
            end else if (r_zone[jdcm_pkg::ZONE_BOTTOM] == jdcm_pkg::ZONE_SLOW &&
                         17'(lin_v) < slow_n) begin
                lin_g = 16'(slow_n);
            end
        end

        ang_g = ang_v;
        if (ang_v < 16'sd0) begin
            if (r_zone[jdcm_pkg::ZONE_TOP_RIGHT] == jdcm_pkg::ZONE_BLOCKED ||
                r_zone[jdcm_pkg::ZONE_BOTTOM_LEFT] == jdcm_pkg::ZONE_BLOCKED) begin
                ang_g = '0;
            end
        end else begin
            if (r_zone[jdcm_pkg::ZONE_TOP_LEFT] == jdcm_pkg::ZONE_BLOCKED ||
                r_zone[jdcm_pkg::ZONE_BOTTOM_RIGHT] == jdcm_pkg::ZONE_BLOCKED) begin
                ang_g = '0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_fs  <= jdcm_pkg::LIN_FS_RST;
            r_ang_fs  <= jdcm_pkg::ANG_FS_RST;
            r_rec_lin <= jdcm_pkg::REC_LIN_RST;
            r_rec_ang <= jdcm_pkg::REC_ANG_RST;
            r_slow    <= jdcm_pkg::SLOW_LIM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jdcm_pkg::CFG_LIN_FS:   r_lin_fs  <= i_cfg_data;
                jdcm_pkg::CFG_ANG_FS:   r_ang_fs  <= i_cfg_data;
                jdcm_pkg::CFG_REC_LIN:  r_rec_lin <= i_cfg_data;
                jdcm_pkg::CFG_REC_ANG:  r_rec_ang <= i_cfg_data;
                jdcm_pkg::CFG_SLOW_LIM: r_slow    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear          <= '0;
            r_armed         <= 1'b0;
            r_clr_prev      <= 1'b0;
            r_rpl_prev      <= 1'b0;
            r_hat_h_prev    <= '0;
            r_hat_v_prev    <= '0;
            r_replay_active <= 1'b0;
            r_count         <= '0;
            for (int i = 0; i < jdcm_pkg::ZONE_COUNT; i++) begin
                r_zone[i] <= jdcm_pkg::ZONE_FREE;
            end
        end else if (i_cmd.load) begin
            if (i_s_tuser) begin
                if (f_slot < 3'(jdcm_pkg::ZONE_COUNT)) r_zone[f_slot] <= f_level;
            end else begin
                r_gear       <= n_gear;
                r_armed      <= n_armed;
                r_clr_prev   <= f_clr;
                r_rpl_prev   <= f_rpl;
                r_hat_h_prev <= f_hh;
                r_hat_v_prev <= f_hv;
                if (clr_edge) r_count <= '0;
                if (rpl_edge) r_replay_active <= 1'b1;
            end
        end else if (i_cmd.fin) begin
            if (pop) begin
                r_count <= cnt_dec;
            end else if (r_replay_active) begin
                r_replay_active <= 1'b0;
            end else if (push) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // record stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && push) r_stack[r_count[AW-1:0]] <= {na, nl};
        if (i_cmd.mul1) r_rd <= r_stack[rd_addr];
    end

    // arithmetic pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lneg <= fwd_c > rev_c;
            r_lmag <= (fwd_c > rev_c) ? (fwd_c - rev_c) : (rev_c - fwd_c);
            r_aneg <= f_turn[15];
            r_amag <= f_turn[15] ? (~f_turn + 16'd1) : f_turn;
            r_step <= n_step;
        end
        if (i_cmd.mul1) begin
            r_pl <= P1_W'(r_lmag * r_lin_fs);
            r_pa <= P1_W'(r_amag * r_ang_fs);
        end
        if (i_cmd.mul2) begin
            r_ml <= P2_W'(r_pl * gear_p1);
            r_ma <= P2_W'(r_pa * gear_p1);
        end
        if (i_cmd.div) begin
            r_ql <= prod_l[SH +: T_W];
            r_qa <= prod_a[SH +: T_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_olin  <= lin_g;
            r_oang  <= ang_g;
            r_ostep <= pop ? '0 : r_step;
            r_owv   <= !pop;
            r_orp   <= pop;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_ostep, r_oang, r_olin};
    assign o_m_tuser  = {r_orp, r_owv};

endmodule

// File: rtl/core/jdcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_checker
// port-level checks of the command mapper, bound to the top level
// ----------------------------------------------------------------------------
module jdcm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [jdcm_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [jdcm_pkg::OUT_TUSER_W-1:0] o_m_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output changed");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] != o_m_tuser[1]))
        else $error("window_valid and replaying not exclusive");

    a_replay_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> (o_m_tdata[36:32] == 5'd0))
        else $error("window step during replay");

    a_zone_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser && !o_m_tvalid |=> !o_m_tvalid)
        else $error("zone update produced output");

endmodule

bind joystick_drive_command_mapper jdcm_checker u_jdcm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: dv/joystick_drive_command_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_drive_command_mapper_tb
// drives gamepad samples and zone updates into the mapper, predicts every
// velocity command in a cycle-free model of its own and checks each output
// transfer against it; runs directed cases, random drive/record/replay
// sequences, a full record stack with long output back-pressure, and several
// register settings including the extremes
// ----------------------------------------------------------------------------
module joystick_drive_command_mapper_tb;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] turn;
        logic [15:0]        thr_fwd;
        logic [15:0]        thr_rev;
        logic               shift_dn;
        logic               shift_up;
        logic               clear_btn;
        logic               replay_btn;
        logic [1:0]         hat_h;
        logic [1:0]         hat_v;
        logic [2:0]         zone_slot;
        logic [1:0]         zone_level;
    } t_joy_item;

    typedef struct packed {
        logic signed [jdcm_pkg::VEL_W-1:0]  lin;
        logic signed [jdcm_pkg::VEL_W-1:0]  ang;
        logic signed [jdcm_pkg::STEP_W-1:0] win_step;
        logic                               win_valid;
        logic                               replaying;
    } t_vel_cmd;

    localparam longint VEL_DEN        = longint'(jdcm_pkg::GEAR_COUNT_DEF) * 32768;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     LONG_HOLD      = 300;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     MAX_REPORTS    = 60;

    localparam logic [jdcm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [2:0]           ZONE_SLOT_SPARE  = 3'd7;
    localparam logic [1:0]           ZONE_LEVEL_SPARE = 2'd3;
    localparam logic [1:0]           HAT_POS          = 2'b01;
    localparam logic [1:0]           HAT_NEG          = 2'b11;
    localparam logic [1:0]           HAT_NEG_ALT      = 2'b10;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [jdcm_pkg::IN_TDATA_W-1:0]     s_tdata;
    logic                                s_tuser;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [jdcm_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic [jdcm_pkg::OUT_TUSER_W-1:0]    m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [jdcm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [jdcm_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    t_joy_item cur_item = '0;
    t_joy_item sample_q[$];
    t_vel_cmd  vel_q[$];

    bit s_taken = 1'b0;
    bit idle_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int quiet_cycles = 0;

    int n_pushed = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_replayed = 0;
    int n_window = 0;
    int n_reg_writes = 0;
    int n_errors = 0;

    // model state
    logic [jdcm_pkg::CFG_DATA_W-1:0] lin_fs, ang_fs, rec_lin_min, rec_ang_min, slow_lim;
    int                    gear_r;
    bit                    shift_armed, clear_prev, replay_prev, replay_on;
    int                    hat_h_prev, hat_v_prev;
    logic [31:0]           move_mem [jdcm_pkg::RECORD_DEPTH_DEF];
    int                    stack_cnt;
    int                    stack_peak = 0;
    logic [1:0]            zone_lvl [jdcm_pkg::ZONE_COUNT];

    assign s_tdata = {3'b000, cur_item.zone_level, cur_item.zone_slot, cur_item.hat_v,
                      cur_item.hat_h, cur_item.replay_btn, cur_item.clear_btn,
                      cur_item.shift_up, cur_item.shift_dn, cur_item.thr_rev,
                      cur_item.thr_fwd, cur_item.turn};
    assign s_tuser = cur_item.mode;

    function automatic void mapper_reset();
        lin_fs      = jdcm_pkg::LIN_FS_RST;
        ang_fs      = jdcm_pkg::ANG_FS_RST;
        rec_lin_min = jdcm_pkg::REC_LIN_RST;
        rec_ang_min = jdcm_pkg::REC_ANG_RST;
        slow_lim    = jdcm_pkg::SLOW_LIM_RST;
        gear_r      = 0;
        shift_armed = 1'b0;
        clear_prev  = 1'b0;
        replay_prev = 1'b0;
        replay_on   = 1'b0;
        hat_h_prev  = 0;
        hat_v_prev  = 0;
        stack_cnt   = 0;
        for (int z = 0; z < jdcm_pkg::ZONE_COUNT; z++) zone_lvl[z] = jdcm_pkg::ZONE_FREE;
    endfunction

    function automatic void mapper_write(logic [jdcm_pkg::CFG_IDX_W-1:0] idx,
                                         logic [jdcm_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            jdcm_pkg::CFG_LIN_FS:   lin_fs = val;
            jdcm_pkg::CFG_ANG_FS:   ang_fs = val;
            jdcm_pkg::CFG_REC_LIN:  rec_lin_min = val;
            jdcm_pkg::CFG_REC_ANG:  rec_ang_min = val;
            jdcm_pkg::CFG_SLOW_LIM: slow_lim = val;
            default: ;
        endcase
    endfunction

    function automatic int clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // x * fs * (gear+1) / (GEAR_COUNT * 32768), rounded half away from zero
    function automatic int scale_vel(longint x, logic [jdcm_pkg::CFG_DATA_W-1:0] fs);
        longint num;
        longint q;
        num = x * longint'(fs) * longint'(gear_r + 1);
        if (num >= 0) q = (num + VEL_DEN / 2) / VEL_DEN;
        else q = -((-num + VEL_DEN / 2) / VEL_DEN);
        return clip16(q);
    endfunction

    function automatic int hat_release(int prev, int now);
        if (prev < 0 && now == 0) return -1;
        if (prev > 0 && now == 0) return 1;
        return 0;
    endfunction

    function automatic void map_sample(t_joy_item it);
        longint   fwd, rev;
        int       lin_i, ang_i, step_i, hs, vs, hh_i, hv_i, slow_i;
        bit       clr_edge, rpl_edge, popped;
        t_vel_cmd cmd;
        if (it.mode) begin
            if (it.zone_slot < jdcm_pkg::ZONE_COUNT) zone_lvl[it.zone_slot] = it.zone_level;
            return;
        end
        fwd = longint'(it.thr_fwd);
        rev = longint'(it.thr_rev);
        if (fwd > 32768) fwd = 32768;
        if (rev > 32768) rev = 32768;

        if (!it.shift_dn && !it.shift_up) shift_armed = 1'b1;
        if (shift_armed && (it.shift_dn ^ it.shift_up)) begin
            if (it.shift_dn) begin
                if (gear_r > 0) gear_r--;
            end else begin
                gear_r++;
            end
            shift_armed = 1'b0;
        end
        if (gear_r > jdcm_pkg::GEAR_COUNT_DEF - 1) gear_r = jdcm_pkg::GEAR_COUNT_DEF - 1;

        lin_i = scale_vel(-(fwd - rev), lin_fs);
        ang_i = scale_vel(longint'($signed(it.turn)), ang_fs);

        clr_edge    = clear_prev && !it.clear_btn;
        rpl_edge    = replay_prev && !it.replay_btn;
        clear_prev  = it.clear_btn;
        replay_prev = it.replay_btn;
        hh_i        = int'($signed(it.hat_h));
        hv_i        = int'($signed(it.hat_v));
        hs          = hat_release(hat_h_prev, hh_i);
        vs          = hat_release(hat_v_prev, hv_i);
        hat_h_prev  = hh_i;
        hat_v_prev  = hv_i;

        if (clr_edge) stack_cnt = 0;
        if (rpl_edge) replay_on = 1'b1;

        popped = 1'b0;
        if (replay_on) begin
            if (stack_cnt > 0) begin
                stack_cnt--;
                lin_i  = int'($signed(move_mem[stack_cnt][15:0]));
                ang_i  = int'($signed(move_mem[stack_cnt][31:16]));
                popped = 1'b1;
            end else begin
                replay_on = 1'b0;
            end
        end else if ((lin_i < 0 ? -lin_i : lin_i) > int'(rec_lin_min) ||
                     (ang_i < 0 ? -ang_i : ang_i) > int'(rec_ang_min)) begin
            if (stack_cnt < jdcm_pkg::RECORD_DEPTH_DEF) begin
                move_mem[stack_cnt] = {16'(clip16(-longint'(ang_i))),
                                       16'(clip16(-longint'(lin_i)))};
                stack_cnt++;
                if (stack_cnt > stack_peak) stack_peak = stack_cnt;
            end
        end

        step_i = 0;
        if (!popped) begin
            if (hs < 0) step_i += int'(jdcm_pkg::STEP_H);
            else if (hs > 0) step_i -= int'(jdcm_pkg::STEP_H);
            if (vs > 0) step_i += int'(jdcm_pkg::STEP_V);
            else if (vs < 0) step_i -= int'(jdcm_pkg::STEP_V);
        end

        slow_i = int'(slow_lim);
        if (lin_i > 0) begin
            if (zone_lvl[jdcm_pkg::ZONE_TOP] == jdcm_pkg::ZONE_BLOCKED) lin_i = 0;
            else if (zone_lvl[jdcm_pkg::ZONE_TOP] == jdcm_pkg::ZONE_SLOW && lin_i > slow_i)
                lin_i = slow_i;
        end else begin
            if (zone_lvl[jdcm_pkg::ZONE_BOTTOM] == jdcm_pkg::ZONE_BLOCKED) lin_i = 0;
            else if (zone_lvl[jdcm_pkg::ZONE_BOTTOM] == jdcm_pkg::ZONE_SLOW &&
                     lin_i < -slow_i)
                lin_i = -slow_i;
        end
        if (ang_i < 0) begin
            if (zone_lvl[jdcm_pkg::ZONE_TOP_RIGHT] == jdcm_pkg::ZONE_BLOCKED ||
                zone_lvl[jdcm_pkg::ZONE_BOTTOM_LEFT] == jdcm_pkg::ZONE_BLOCKED) ang_i = 0;
        end else begin
            if (zone_lvl[jdcm_pkg::ZONE_TOP_LEFT] == jdcm_pkg::ZONE_BLOCKED ||
                zone_lvl[jdcm_pkg::ZONE_BOTTOM_RIGHT] == jdcm_pkg::ZONE_BLOCKED) ang_i = 0;
        end

        cmd.lin       = 16'(lin_i);
        cmd.ang       = 16'(ang_i);
        cmd.win_step  = 5'(step_i);
        cmd.win_valid = !popped;
        cmd.replaying = popped;
        vel_q.insert(vel_q.size(), cmd);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     n_results, what, got, want);
    endtask

    task automatic check_command();
        t_vel_cmd got, want;
        got.lin       = m_tdata[15:0];
        got.ang       = m_tdata[31:16];
        got.win_step  = m_tdata[36:32];
        got.win_valid = m_tuser[0];
        got.replaying = m_tuser[1];
        if (vel_q.size() == 0) begin
            report_mismatch("output transfer with none outstanding", 1, 0);
        end else begin
            want = vel_q.pop_front();
            if (got.lin !== want.lin)
                report_mismatch("linear_velocity", int'(got.lin), int'(want.lin));
            if (got.ang !== want.ang)
                report_mismatch("angular_velocity", int'(got.ang), int'(want.ang));
            if (got.win_step !== want.win_step)
                report_mismatch("window_step", int'(got.win_step), int'(want.win_step));
            if (got.win_valid !== want.win_valid)
                report_mismatch("window_valid", int'(got.win_valid), int'(want.win_valid));
            if (got.replaying !== want.replaying)
                report_mismatch("replaying", int'(got.replaying), int'(want.replaying));
            if (want.replaying) n_replayed++;
            if (want.win_valid && want.win_step != 0) n_window++;
        end
        n_results++;
    endtask

    joystick_drive_command_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sample driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || s_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                cur_item <= sample_q.pop_front();
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0) gap_left <= $urandom_range(1, 17);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // command receiver
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor, model update and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mapper_reset();
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                map_sample(cur_item);
                n_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                mapper_write(cfg_index, cfg_data);
                n_reg_writes++;
            end
            if (m_tvalid && m_tready) check_command();
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic t_joy_item mk_move(int turn, int fwd, int rev);
        t_joy_item it;
        it         = '0;
        it.turn    = 16'(turn);
        it.thr_fwd = 16'(fwd);
        it.thr_rev = 16'(rev);
        return it;
    endfunction

    function automatic t_joy_item mk_zone(logic [2:0] slot, logic [1:0] lvl);
        t_joy_item it;
        it            = '0;
        it.mode       = 1'b1;
        it.zone_slot  = slot;
        it.zone_level = lvl;
        it.turn       = 16'($urandom);
        it.thr_fwd    = 16'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] rand_throttle();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [1:0] rand_hat();
        case ($urandom_range(0, 2))
            0: return HAT_POS;
            1: return HAT_NEG;
            default: return HAT_NEG_ALT;
        endcase
    endfunction

    function automatic t_joy_item rand_move();
        t_joy_item it;
        it            = mk_move($urandom, rand_throttle(), rand_throttle());
        it.zone_slot  = 3'($urandom);
        it.zone_level = 2'($urandom);
        return it;
    endfunction

    task automatic push(t_joy_item it);
        sample_q.insert(sample_q.size(), it);
        n_pushed++;
    endtask

    // moves with the odd shoulder press or hat flick
    task automatic drive_stretch(int n);
        t_joy_item it;
        for (int k = 0; k < n; k++) begin
            it = rand_move();
            case ($urandom_range(0, 9))
                0, 1: it.shift_up = 1'b1;
                2: it.shift_dn = 1'b1;
                3: {it.shift_up, it.shift_dn} = 2'b11;
                4: it.hat_h = rand_hat();
                5: it.hat_v = rand_hat();
                6: begin
                    it.hat_h = rand_hat();
                    it.hat_v = rand_hat();
                end
                default: ;
            endcase
            push(it);
        end
    endtask

    task automatic run_episodes(int n_items);
        int        first, n, slot;
        t_joy_item it;
        first = n_pushed;
        while (n_pushed - first < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: drive_stretch($urandom_range(2, 10));
                4, 5: begin
                    n = $urandom_range(1, 12);
                    drive_stretch(n);
                    it = rand_move();
                    it.replay_btn = 1'b1;
                    push(it);
                    drive_stretch(n + 3);
                end
                6: begin
                    it = rand_move();
                    it.clear_btn = 1'b1;
                    push(it);
                    drive_stretch($urandom_range(1, 4));
                end
                7: begin
                    slot = $urandom_range(0, 7);
                    push(mk_zone(3'(slot), 2'($urandom)));
                    drive_stretch($urandom_range(1, 5));
                    if ($urandom_range(0, 1)) push(mk_zone(3'(slot), jdcm_pkg::ZONE_FREE));
                end
                default: begin
                    it            = rand_move();
                    it.mode       = ($urandom_range(0, 3) == 0);
                    it.shift_dn   = 1'($urandom);
                    it.shift_up   = 1'($urandom);
                    it.clear_btn  = 1'($urandom);
                    it.replay_btn = 1'($urandom);
                    it.hat_h      = 2'($urandom);
                    it.hat_v      = 2'($urandom);
                    push(it);
                end
            endcase
        end
    endtask

    task automatic run_directed();
        t_joy_item it;
        push(mk_zone(jdcm_pkg::ZONE_TOP, ZONE_LEVEL_SPARE));
        push(mk_zone(3'(jdcm_pkg::ZONE_COUNT), jdcm_pkg::ZONE_BLOCKED));
        push(mk_zone(ZONE_SLOT_SPARE, jdcm_pkg::ZONE_BLOCKED));
        // gear shifting, throttle saturation and stick extremes
        push(mk_move(32767, 0, 0));
        it = mk_move(-32768, 65535, 0);
        it.shift_up = 1'b1;
        push(it);
        it = mk_move(0, 0, 65535);
        {it.shift_up, it.shift_dn} = 2'b11;
        push(it);
        push(mk_move(0, 0, 0));
        it = mk_move(0, 32768, 32768);
        it.shift_dn = 1'b1;
        push(it);
        push(mk_move(0, 0, 0));
        it = mk_move(-1, 1, 0);
        it.shift_dn = 1'b1;
        push(it);
        // hat releases, including the alternate negative pattern
        it = mk_move(1000, 0, 0);
        it.hat_h = HAT_NEG;
        push(it);
        push(mk_move(1000, 0, 0));
        it = mk_move(0, 0, 0);
        it.hat_h = HAT_POS;
        it.hat_v = HAT_POS;
        push(it);
        push(mk_move(0, 0, 0));
        it = mk_move(0, 0, 0);
        it.hat_h = HAT_NEG_ALT;
        it.hat_v = HAT_NEG;
        push(it);
        push(mk_move(0, 0, 0));
        // clear, then record two moves and replay them
        it = mk_move(0, 32768, 0);
        it.clear_btn = 1'b1;
        push(it);
        push(mk_move(0, 0, 0));
        push(mk_move(20000, 30000, 0));
        it = mk_move(-20000, 0, 30000);
        it.replay_btn = 1'b1;
        push(it);
        it = mk_move(0, 0, 0);
        it.hat_h = HAT_POS;
        push(it);
        push(mk_move(0, 0, 0));
        push(mk_move(0, 0, 0));
        // zone gating
        push(mk_zone(jdcm_pkg::ZONE_TOP, jdcm_pkg::ZONE_SLOW));
        push(mk_zone(jdcm_pkg::ZONE_BOTTOM, jdcm_pkg::ZONE_BLOCKED));
        push(mk_zone(jdcm_pkg::ZONE_TOP_RIGHT, jdcm_pkg::ZONE_BLOCKED));
        push(mk_move(-32768, 0, 32768));
        push(mk_move(12345, 32768, 0));
        push(mk_zone(jdcm_pkg::ZONE_TOP, jdcm_pkg::ZONE_FREE));
        push(mk_zone(jdcm_pkg::ZONE_BOTTOM, jdcm_pkg::ZONE_FREE));
        push(mk_zone(jdcm_pkg::ZONE_TOP_RIGHT, jdcm_pkg::ZONE_FREE));
    endtask

    task automatic write_reg(logic [jdcm_pkg::CFG_IDX_W-1:0] idx,
                             logic [jdcm_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [jdcm_pkg::CFG_DATA_W-1:0] lin_v,
                             logic [jdcm_pkg::CFG_DATA_W-1:0] ang_v,
                             logic [jdcm_pkg::CFG_DATA_W-1:0] rl_v,
                             logic [jdcm_pkg::CFG_DATA_W-1:0] ra_v,
                             logic [jdcm_pkg::CFG_DATA_W-1:0] slow_v);
        write_reg(jdcm_pkg::CFG_LIN_FS, lin_v);
        write_reg(jdcm_pkg::CFG_ANG_FS, ang_v);
        write_reg(jdcm_pkg::CFG_REC_LIN, rl_v);
        write_reg(jdcm_pkg::CFG_REC_ANG, ra_v);
        write_reg(jdcm_pkg::CFG_SLOW_LIM, slow_v);
    endtask

    // every sample transferred and answered, plus room for a trailing zone update
    task automatic wait_drained();
        while (n_accepted != n_pushed || vel_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        t_joy_item it;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_drained();

        write_all(15'($urandom), 15'($urandom), 15'($urandom_range(0, 2000)),
                  15'($urandom_range(0, 8000)), 15'($urandom));
        run_episodes(200);
        wait_drained();

        write_all(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        run_episodes(120);
        wait_drained();

        write_all(15'h0000, 15'($urandom), 15'h0000, 15'h0000, 15'h0000);
        write_reg(CFG_IDX_SPARE, 15'h7FFF);
        run_episodes(120);
        wait_drained();

        // fill the stack past its depth under long output back-pressure, then replay it
        write_all(jdcm_pkg::LIN_FS_RST, jdcm_pkg::ANG_FS_RST, jdcm_pkg::REC_LIN_RST,
                  jdcm_pkg::REC_ANG_RST, jdcm_pkg::SLOW_LIM_RST);
        hold_req++;
        it = mk_move(0, 0, 0);
        it.clear_btn = 1'b1;
        push(it);
        push(mk_move(0, 0, 0));
        for (int k = 0; k < jdcm_pkg::RECORD_DEPTH_DEF + 14; k++)
            push(mk_move($urandom, $urandom_range(16000, 32768), 0));
        it = mk_move(0, 32768, 0);
        it.replay_btn = 1'b1;
        push(it);
        for (int k = 0; k < jdcm_pkg::RECORD_DEPTH_DEF + 4; k++) push(rand_move());
        wait_drained();

        idle_on = 1'b0;
        write_all(15'($urandom), 15'($urandom), 15'($urandom_range(0, 4000)),
                  15'($urandom_range(0, 8000)), 15'($urandom_range(0, 4000)));
        run_episodes(120);
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("covered %0d input transfers, %0d commands checked",
                 n_accepted, n_results);
        $display("%0d replayed, %0d window steps, register writes %0d, %s %0d, mismatches %0d",
                 n_replayed, n_window, n_reg_writes, "deepest record stack", stack_peak,
                 n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: joystick_drive_command_mapper.f
rtl/core/jdcm_pkg.sv
rtl/core/jdcm_ctrl.sv
rtl/core/jdcm_dp.sv
rtl/core/joystick_drive_command_mapper.sv
rtl/core/jdcm_checker.sv
dv/joystick_drive_command_mapper_tb.sv
